[src/sbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sbp_pkg;

    localparam int WIDTH_DEF   = 32;
    localparam int IN_W        = 32;
    localparam int RUN_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int MAX_RESULTS = 47;
    localparam int NRES_W      = $clog2(MAX_RESULTS);
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 40;

    localparam logic [STATUS_W-1:0] ST_RUN     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic DIR_L = 1'b0;
    localparam logic DIR_R = 1'b1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic op_zero;
        logic op_equal;
        logic dir;
        logic rem_zero;
    } t_dp_sts;

endpackage
`default_nettype wire

[src/stern_brocot_path_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stern-Brocot path finder: takes a fraction numerator/denominator and
// reports its path from 1/1 in the Stern-Brocot tree as runs of L (0) or
// R (1) steps; the final run of a fraction carries tlast. A run is found as
// one Euclidean quotient, computed by a restoring divider that yields one
// quotient bit per cycle; each run takes WIDTH divide steps and then one
// step to emit. The block is ready for the next fraction in the cycle in
// which the last result of a fraction appears in the output register; a
// zero operand (status invalid) or equal operands (status empty path, e.g.
// 1/1) give a single result, registered from the check state that follows
// acceptance. The walk waits while the receiver holds the output register.
// Fractions need not be in lowest terms. The block works on one fraction at
// a time; it takes the next one while the final result of the previous one
// still waits in the output register. At WIDTH 32 no path has more than 47
// runs; at a larger WIDTH the walk stops after 47 runs, the 47th marked last.
module stern_brocot_path_finder #(
    parameter int WIDTH = sbp_pkg::WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side: [31:0] numerator, [63:32] denominator
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [sbp_pkg::TDATA_IN_W-1:0]   i_s_tdata,
    // master side: [0] direction, [32:1] run_length, [39:33] zero
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [sbp_pkg::TDATA_OUT_W-1:0]       o_m_tdata,
    // [1:0] status
    output logic [sbp_pkg::STATUS_W-1:0]          o_m_tuser,
    output logic                                  o_m_tlast
);

    sbp_pkg::t_dp_cmd              w_cmd;
    sbp_pkg::t_dp_sts              w_sts;
    logic [sbp_pkg::RUN_W-1:0]     w_dp_len;
    logic                          w_dir;
    logic [sbp_pkg::RUN_W-1:0]     w_len;

    // sequencer: handshakes, divide step count, run count, output register
    sbp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .i_len       (w_dp_len),
        .o_dir       (w_dir),
        .o_len       (w_len),
        .o_status    (o_m_tuser),
        .o_last      (o_m_tlast)
    );

    // operands and the shared divider
    sbp_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk (i_clk),
        .i_num (i_s_tdata[sbp_pkg::IN_W-1:0]),
        .i_den (i_s_tdata[2*sbp_pkg::IN_W-1:sbp_pkg::IN_W]),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_len (w_dp_len)
    );

    // pack direction low, run length above, pad to whole bytes
    assign o_m_tdata = {(sbp_pkg::TDATA_OUT_W - sbp_pkg::RUN_W - 1)'(0), w_len, w_dir};

endmodule
`default_nettype wire

[src/sbp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module sbp_datapath #(
    parameter int WIDTH = sbp_pkg::WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic [sbp_pkg::IN_W-1:0] i_num,
    input  wire logic [sbp_pkg::IN_W-1:0] i_den,
    input  wire sbp_pkg::t_dp_cmd         i_cmd,
    output sbp_pkg::t_dp_sts              o_sts,
    output logic [sbp_pkg::RUN_W-1:0]     o_len
);

    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic             r_dir;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;

    logic [sbp_pkg::IN_W+WIDTH-1:0]  w_num_ext;
    logic [sbp_pkg::IN_W+WIDTH-1:0]  w_den_ext;
    logic [WIDTH-1:0]                w_a_nx;
    logic [WIDTH-1:0]                w_b_nx;
    logic                            w_a_gt_b;
    logic [WIDTH:0]                  w_rem_sh;
    logic [WIDTH:0]                  w_dvs_ext;
    logic [WIDTH:0]                  w_diff;
    logic                            w_ge;
    logic                            w_rem_zero;
    logic [WIDTH-1:0]                w_len_full;
    logic [sbp_pkg::RUN_W+WIDTH-1:0] w_len_ext;

    // operands are taken modulo 2^WIDTH
    assign w_num_ext = {WIDTH'(0), i_num};
    assign w_den_ext = {WIDTH'(0), i_den};

    // operands after this cycle's update, so the next division starts on them
    assign w_a_nx   = (i_cmd.update && r_dir == sbp_pkg::DIR_R) ? r_rem : r_a;
    assign w_b_nx   = (i_cmd.update && r_dir == sbp_pkg::DIR_L) ? r_rem : r_b;
    assign w_a_gt_b = w_a_nx > w_b_nx;

    // restoring division, one quotient bit per step
    assign w_rem_sh  = {r_rem, r_quo[WIDTH-1]};
    assign w_dvs_ext = {1'b0, r_dvs};
    assign w_diff    = w_rem_sh - w_dvs_ext;
    assign w_ge      = w_rem_sh >= w_dvs_ext;

    assign w_rem_zero = r_rem == '0;
    // a run whose division leaves no remainder ends the path and is one step shorter than the quotient
    assign w_len_full = w_rem_zero ? r_quo - WIDTH'(1) : r_quo;
    assign w_len_ext  = {sbp_pkg::RUN_W'(0), w_len_full};
    assign o_len      = w_len_ext[sbp_pkg::RUN_W-1:0];

    assign o_sts = '{
        op_zero:  (r_a == '0) || (r_b == '0),
        op_equal: r_a == r_b,
        dir:      r_dir,
        rem_zero: w_rem_zero
    };

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= w_num_ext[WIDTH-1:0];
            r_b <= w_den_ext[WIDTH-1:0];
        end else if (i_cmd.update) begin
            if (r_dir == sbp_pkg::DIR_R) begin
                r_a <= r_rem;
            end else begin
                r_b <= r_rem;
            end
        end

        if (i_cmd.div_start) begin
            r_dir <= w_a_gt_b ? sbp_pkg::DIR_R : sbp_pkg::DIR_L;
            r_quo <= w_a_gt_b ? w_a_nx : w_b_nx;
            r_dvs <= w_a_gt_b ? w_b_nx : w_a_nx;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_rem_sh[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

[src/sbp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module sbp_ctrl #(
    parameter int WIDTH = sbp_pkg::WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output sbp_pkg::t_dp_cmd                  o_cmd,
    input  wire sbp_pkg::t_dp_sts             i_sts,
    input  wire logic [sbp_pkg::RUN_W-1:0]    i_len,
    output logic                              o_dir,
    output logic [sbp_pkg::RUN_W-1:0]         o_len,
    output logic [sbp_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_PUT
    } t_state;

    t_state                        r_state;
    logic [CNT_W-1:0]              r_cnt;
    logic [sbp_pkg::NRES_W-1:0]    r_nres;
    logic                          r_valid;
    logic                          r_dir;
    logic [sbp_pkg::RUN_W-1:0]     r_len;
    logic [sbp_pkg::STATUS_W-1:0]  r_status;
    logic                          r_last;

    logic w_free;
    logic w_accept;
    logic w_special;
    logic w_run_last;

    assign w_free     = !r_valid || i_out_ready;
    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_special  = i_sts.op_zero || i_sts.op_equal;
    assign w_run_last = i_sts.rem_zero ||
                        (r_nres == sbp_pkg::NRES_W'(sbp_pkg::MAX_RESULTS - 1));

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_valid;
    assign o_dir       = r_dir;
    assign o_len       = r_len;
    assign o_status    = r_status;
    assign o_last      = r_last;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
            end
            S_CHECK: begin
                o_cmd.div_start = !w_special;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_PUT: begin
                o_cmd.update    = w_free;
                o_cmd.div_start = w_free && !w_run_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_nres  <= '0;
        end else begin
            if (r_valid && i_out_ready) begin
                r_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_nres  <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_special) begin
                        if (w_free) begin
                            r_valid  <= 1'b1;
                            r_dir    <= sbp_pkg::DIR_L;
                            r_len    <= '0;
                            r_status <= i_sts.op_zero ? sbp_pkg::ST_INVALID
                                                      : sbp_pkg::ST_EMPTY;
                            r_last   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_cnt   <= CNT_W'(WIDTH - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_PUT;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_PUT: begin
                    if (w_free) begin
                        r_valid  <= 1'b1;
                        r_dir    <= i_sts.dir;
                        r_len    <= i_len;
                        r_status <= sbp_pkg::ST_RUN;
                        r_last   <= w_run_last;
                        r_nres   <= r_nres + sbp_pkg::NRES_W'(1);
                        if (w_run_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= CNT_W'(WIDTH - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
